@@ src/urtd_pkg.sv @@
package urtd_pkg;

  // fixed field widths
  localparam int VALUE_BITS     = 64;
  localparam int RADIX_BITS     = 5;
  localparam int ALPHA_BITS     = 64;
  localparam int CHAR_BITS      = 8;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;

  // parameter defaults
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_RADIX_DEF   = 16;

  // quotient bits handled by the divider per cycle
  localparam int DIV_STEP = 8;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_HIGH = 2'd2;

  // register reset values
  localparam logic [RADIX_BITS-1:0] RADIX_RESET      = 5'd10;
  localparam logic [ALPHA_BITS-1:0] ALPHA_LOW_RESET  = 64'h3736353433323130;
  localparam logic [ALPHA_BITS-1:0] ALPHA_HIGH_RESET = 64'h6665646362613938;

  typedef struct packed {
    logic load;   // take a new value, clear the digit count
    logic step;   // advance the divider by one chunk
    logic rd;     // fetch the digit at the read pointer
    logic next;   // digit delivered, move the read pointer down
  } urtd_cmd_t;

  typedef struct packed {
    logic chunk_last;  // this divider cycle finishes a digit
    logic div_done;    // no more digits after this one
    logic rd_last;     // read pointer sits on the least significant digit
  } urtd_sts_t;

endpackage

@@ src/urtd_dpath.sv @@
module urtd_dpath #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_RADIX   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [urtd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [urtd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [urtd_pkg::VALUE_BITS-1:0]     value,
  input  urtd_pkg::urtd_cmd_t                 cmd,
  output urtd_pkg::urtd_sts_t                 sts,
  output logic [urtd_pkg::CHAR_BITS-1:0]      digit_char
);
  import urtd_pkg::*;

  localparam int CHUNKS = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int QW     = CHUNKS * DIV_STEP;
  localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int DEPTH  = VALUE_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int RW     = $clog2(MAX_RADIX);
  localparam int TW     = RW + 1;
  localparam int RADW   = $clog2(MAX_RADIX + 1);

  logic [RADIX_BITS-1:0] radix;
  logic [ALPHA_BITS-1:0] alpha_low;
  logic [ALPHA_BITS-1:0] alpha_high;

  logic [QW-1:0]    q;
  logic [QW-1:0]    q_next;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    rem_next;
  logic [CKW-1:0]   chunk;
  logic [CW-1:0]    count;
  logic [AW-1:0]    rd_ptr;
  logic [RW-1:0]    rd_data;
  logic [RADW-1:0]  r_eff;
  logic [DIV_STEP-1:0] qbits;
  logic [DIV_STEP-1:0] top;

  logic [RW-1:0] mem [DEPTH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= RADIX_RESET;
      alpha_low  <= ALPHA_LOW_RESET;
      alpha_high <= ALPHA_HIGH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIX:      radix      <= cfg_data[RADIX_BITS-1:0];
        REG_ALPHA_LOW:  alpha_low  <= cfg_data;
        REG_ALPHA_HIGH: alpha_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp radix into 2..MAX_RADIX
  always_comb begin
    if (radix < RADIX_BITS'(2)) begin
      r_eff = RADW'(2);
    end else if (radix > RADIX_BITS'(MAX_RADIX)) begin
      r_eff = RADW'(MAX_RADIX);
    end else begin
      r_eff = radix[RADW-1:0];
    end
  end

  assign top = q[QW-1 -: DIV_STEP];

  // restoring long division over the top chunk of the quotient
  always_comb begin
    logic [TW-1:0] trial;
    logic [RW-1:0] r_w;
    r_w   = rem;
    qbits = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      trial = {r_w, top[i]};
      if (trial >= TW'(r_eff)) begin
        trial    = trial - TW'(r_eff);
        qbits[i] = 1'b1;
      end
      r_w = trial[RW-1:0];
    end
    rem_next = r_w;
  end

  // quotient bits rotate in at the bottom, after all chunks q is the new quotient
  assign q_next = (q << DIV_STEP) | QW'(qbits);

  assign sts.chunk_last = (chunk == CKW'(CHUNKS - 1));
  assign sts.div_done   = (q_next == '0) || (count == CW'(DEPTH - 1));
  assign sts.rd_last    = (rd_ptr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem   <= '0;
      chunk <= '0;
      count <= '0;
    end else if (cmd.load) begin
      rem   <= '0;
      chunk <= '0;
      count <= '0;
    end else if (cmd.step) begin
      if (sts.chunk_last) begin
        rem   <= '0;
        chunk <= '0;
        count <= count + CW'(1);
      end else begin
        rem   <= rem_next;
        chunk <= chunk + CKW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q <= QW'(value[VALUE_WIDTH-1:0]);
    end else if (cmd.step) begin
      q <= q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && sts.chunk_last) begin
      rd_ptr <= count[AW-1:0];
    end else if (cmd.next) begin
      rd_ptr <= rd_ptr - AW'(1);
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (cmd.step && sts.chunk_last) begin
      mem[count[AW-1:0]] <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // alphabet lookup
  always_comb begin
    logic [2*ALPHA_BITS-1:0] alpha;
    logic [3:0]              idx;
    alpha      = {alpha_high, alpha_low};
    idx        = 4'(rd_data);
    digit_char = alpha[{idx, 3'b000} +: CHAR_BITS];
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (CW'(rd_ptr) < count))
    else $error("digit read beyond the stored digits");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    RADW'(rem) < r_eff)
    else $error("running remainder not below the radix");

endmodule

@@ src/urtd_ctrl.sv @@
module urtd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                last,
  input  urtd_pkg::urtd_sts_t sts,
  output urtd_pkg::urtd_cmd_t cmd
);
  import urtd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_SHOW = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_SHOW);
  assign last      = sts.rd_last;

  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.step = (state == S_DIV);
  assign cmd.rd   = (state == S_READ);
  assign cmd.next = (state == S_SHOW) && !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.chunk_last && sts.div_done) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall) state_next = sts.rd_last ? S_IDLE : S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_request_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while digits are being sent");

  a_last_ends_number: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> (!out_valid && !in_stall))
    else $error("output continues after the last digit");

endmodule

@@ src/unsigned_radix_to_digits.sv @@
// Converts one unsigned value to its digit characters in a radix from 2 to MAX_RADIX,
// most significant first with no leading zeros, last high on the final character. The
// value is taken only while the block is idle. A shared divider reduces the running
// quotient by DIV_STEP bits per cycle, working through every chunk of it for each digit;
// each character is then read from the digit store and shown on the output, where it
// is held while the output stalls.
module unsigned_radix_to_digits #(
  parameter int VALUE_WIDTH = urtd_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_RADIX   = urtd_pkg::MAX_RADIX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [urtd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [urtd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [urtd_pkg::VALUE_BITS-1:0]     value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [urtd_pkg::CHAR_BITS-1:0]      digit_char,
  output logic                                last
);
  import urtd_pkg::*;

  urtd_cmd_t cmd;
  urtd_sts_t sts;

  urtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last      (last),
    .sts       (sts),
    .cmd       (cmd)
  );

  urtd_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_RADIX   (MAX_RADIX)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .digit_char (digit_char)
  );

endmodule
